[src/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classification function for the
// base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SEXTET_BITS = 6;
    localparam int BYTE_BITS   = 8;

    typedef struct packed {
        logic       last;
        logic       pad;
        logic       skip;
        logic [5:0] sextet;
    } t_class_item;

    function automatic t_class_item classify(input logic [7:0] c, input logic last);
        t_class_item r;
        r.last   = last;
        r.pad    = 1'b0;
        r.skip   = 1'b0;
        r.sextet = 6'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            r.sextet = 6'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            r.sextet = 6'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r.sextet = 6'(c + 8'd4);
        end else if (c == 8'd43) begin
            r.sextet = 6'd62;
        end else if (c == 8'd47) begin
            r.sextet = 6'd63;
        end else if (c == 8'd61) begin
            r.pad = 1'b1;
        end else begin
            r.skip = 1'b1;
        end
        return r;
    endfunction

endpackage

[src/base64_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 stream decoder: one character in, one result out per transaction.
//
// Channel  Direction  Handshake     Payload
// input    in         push / full   i_char_in, i_end_of_message
// result   out        empty / pop   o_byte_valid, o_data_byte, o_message_done
//
// One character is accepted per cycle while full is low. It passes the input
// stage register, the queue and the decoder's output register to the output.
// The input stage classification and the decoder shift are combinational.
// Reset is synchronous and active low; it clears all held bits and the queue.
// The classify queue lets input continue while the result side is stalled.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
    parameter int P_QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic       o_byte_valid,
    output logic [7:0] o_data_byte,
    output logic       o_message_done
);

    logic                  w_q_push;
    logic                  w_q_full;
    logic                  w_q_pop;
    logic                  w_q_empty;
    b64d_pkg::t_class_item w_front_item;
    b64d_pkg::t_class_item w_back_item;

    b64d_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_char_in        (i_char_in),
        .i_end_of_message (i_end_of_message),
        .o_q_push         (w_q_push),
        .o_q_item         (w_front_item),
        .i_q_full         (w_q_full)
    );

    b64d_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_back_item),
        .o_empty (w_q_empty)
    );

    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_item       (w_back_item),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_byte_valid   (o_byte_valid),
        .o_data_byte    (o_data_byte),
        .o_message_done (o_message_done)
    );

endmodule

[src/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front
// Input stage: accepts one character per transaction, classifies it and
// holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_char_in,
    input  logic                  i_end_of_message,
    output logic                  o_q_push,
    output b64d_pkg::t_class_item o_q_item,
    input  logic                  i_q_full
);

    logic                  r_valid;
    logic                  n_valid;
    b64d_pkg::t_class_item r_item;
    b64d_pkg::t_class_item n_item;
    logic                  w_accept;
    logic                  w_drain;

    assign full     = r_valid && i_q_full;
    assign w_accept = push && !full;
    assign w_drain  = r_valid && !i_q_full;
    assign o_q_push = r_valid;
    assign o_q_item = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (w_accept) begin
            n_valid = 1'b1;
            n_item  = b64d_pkg::classify(i_char_in, i_end_of_message);
        end else if (w_drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

[src/b64d_queue.sv]
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of classified items between the input stage and the decoder.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int P_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b64d_pkg::t_class_item i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output b64d_pkg::t_class_item o_item,
    output logic                  o_empty
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    b64d_pkg::t_class_item r_mem [P_DEPTH];
    logic [AW-1:0]         r_wr_ptr;
    logic [AW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         n_wr_ptr;
    logic [AW-1:0]         n_rd_ptr;
    logic [CW-1:0]         n_count;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("queue count exceeds depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a write");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(P_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");
`endif

endmodule

[src/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back
// Decoder stage: merges sextets into the bit accumulator, emits bytes and
// holds one result in an output register until it is popped.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b64d_pkg::t_class_item i_q_item,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_byte_valid,
    output logic [7:0]            o_data_byte,
    output logic                  o_message_done
);

    logic        r_out_valid;
    logic        r_byte_valid;
    logic [7:0]  r_data_byte;
    logic        r_done;
    logic [5:0]  r_residual;
    logic [2:0]  r_held;
    logic        r_pad;
    logic        n_byte_valid;
    logic [7:0]  n_data_byte;
    logic [5:0]  n_residual;
    logic [2:0]  n_held;
    logic        n_pad;
    logic        w_take;
    logic [11:0] w_acc;
    logic [3:0]  w_total;
    logic [3:0]  w_rem;

    assign w_take         = !i_q_empty && (!r_out_valid || pop);
    assign o_q_pop        = w_take;
    assign empty          = !r_out_valid;
    assign o_byte_valid   = r_byte_valid;
    assign o_data_byte    = r_data_byte;
    assign o_message_done = r_done;

    assign w_acc   = {r_residual, i_q_item.sextet};
    assign w_total = 4'(r_held) + 4'(b64d_pkg::SEXTET_BITS);
    assign w_rem   = w_total - 4'(b64d_pkg::BYTE_BITS);

    always_comb begin
        n_byte_valid = 1'b0;
        n_data_byte  = 8'd0;
        n_residual   = r_residual;
        n_held       = r_held;
        n_pad        = r_pad;
        if (!r_pad) begin
            if (i_q_item.pad) begin
                n_pad = 1'b1;
            end else if (!i_q_item.skip) begin
                if (w_total >= 4'(b64d_pkg::BYTE_BITS)) begin
                    n_byte_valid = 1'b1;
                    n_data_byte  = 8'(w_acc >> w_rem);
                    n_residual   = 6'(w_acc & ((12'd1 << w_rem) - 12'd1));
                    n_held       = 3'(w_rem);
                end else begin
                    n_residual = w_acc[5:0];
                    n_held     = 3'(w_total);
                end
            end
        end
        if (i_q_item.last) begin
            n_residual = 6'd0;
            n_held     = 3'd0;
            n_pad      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_residual  <= 6'd0;
            r_held      <= 3'd0;
            r_pad       <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_residual  <= n_residual;
                r_held      <= n_held;
                r_pad       <= n_pad;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_take) begin
            r_byte_valid <= n_byte_valid;
            r_data_byte  <= n_data_byte;
            r_done       <= i_q_item.last;
        end
    end

`ifndef SYNTHESIS
    a_held_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held[0] == 1'b0 && r_held <= 3'd6)
        else $error("held bit count is not 0, 2, 4 or 6");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_q_item.last) |=> (r_held == 3'd0 && !r_pad && r_residual == 6'd0))
        else $error("state not cleared after end of message");
    a_skip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_q_item.last && (i_q_item.skip || r_pad))
        |=> ($stable(r_residual) && $stable(r_held) && !r_byte_valid))
        else $error("skipped character changed decoder state");
`endif

endmodule
